// ===== src/trt_pkg.sv =====
// ----------------------------------------------------------------------------
// trt_pkg
// Shared types and constants of the tree route table.
// ----------------------------------------------------------------------------
package trt_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned AddrW        = 8;
  localparam int unsigned CntW         = 9;

  typedef enum logic [2:0] {
    FUNC_ALLOC  = 3'd0,
    FUNC_ADD    = 3'd1,
    FUNC_DELETE = 3'd2,
    FUNC_ROUTE  = 3'd3,
    FUNC_REINIT = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ALLOC_RD,
    ST_ALLOC_CHK,
    ST_DEL_RD,
    ST_DEL_CHK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_ROUTE_RD,
    ST_ROUTE_CHK,
    ST_DONE
  } state_t;

  // table port requests from the sequencer
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [AddrW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage : trt_pkg

// ===== src/tree_route_table_top.sv =====
// Add and unknown codes go straight to the result; allocate, route and delete
// (254 entries, each with a chain walk) step through reads on the single
// registered table read port, and reinit clears every entry in turn.
// Throughput: one item in flight; in_tready is high from the cycle after the result is taken.
// Reset (rst_n, synchronous, active low) clears control and local address, then a
// pass over all 256 entries clears the table while in_tready stays low.
// ----------------------------------------------------------------------------
// tree_route_table_top
// Parent-pointer routing table with allocate, add, delete, route and reinit.
// ----------------------------------------------------------------------------
module tree_route_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // func[2:0], target_address[10:3], parent_address[18:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // result_address[7:0], ok[8]
);

  logic [7:0] local_r;
  logic       busy, done, ok;
  logic [7:0] res, rdata;
  trt_pkg::mem_req_t req;

  // local address register
  always_ff @(posedge clk) begin
    if (!rst_n) local_r <= '0;
    else if (cfg_we) local_r <= cfg_wdata;
  end

  trt_seq u_seq (
    .clk(clk), .rst_n(rst_n), .self_addr(local_r),
    .start(in_tvalid && !busy), .func(in_tdata[2:0]),
    .tgt(in_tdata[10:3]), .par(in_tdata[18:11]),
    .busy(busy), .done(done), .res(res), .ok(ok),
    .res_taken(out_tready), .req(req), .rdata(rdata)
  );

  trt_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  assign in_tready  = !busy;
  assign out_tvalid = done;
  assign out_tdata  = {7'd0, ok, res};

endmodule : tree_route_table_top

// ===== src/trt_ram.sv =====
// ----------------------------------------------------------------------------
// trt_ram
// Parent table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module trt_ram (
  input  logic                        clk,
  input  trt_pkg::mem_req_t           req,
  output logic [trt_pkg::AddrW-1:0]   rdata
);

  logic [trt_pkg::AddrW-1:0] mem [trt_pkg::TableEntries];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule : trt_ram

// ===== src/trt_seq.sv =====
// ----------------------------------------------------------------------------
// trt_seq
// Sequencer: runs each command as a series of table reads and writes with
// compares on the read word.
// ----------------------------------------------------------------------------
module trt_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [trt_pkg::AddrW-1:0]  self_addr,
  input  logic                       start,
  input  logic [2:0]                 func,
  input  logic [trt_pkg::AddrW-1:0]  tgt,
  input  logic [trt_pkg::AddrW-1:0]  par,
  output logic                       busy,
  output logic                       done,
  output logic [trt_pkg::AddrW-1:0]  res,
  output logic                       ok,
  input  logic                       res_taken,
  output trt_pkg::mem_req_t          req,
  input  logic [trt_pkg::AddrW-1:0]  rdata
);

  localparam logic [trt_pkg::CntW-1:0] Last = trt_pkg::CntW'(trt_pkg::TableEntries - 1);
  localparam logic [trt_pkg::CntW-1:0] Lim  = trt_pkg::CntW'(trt_pkg::TableEntries);
  localparam logic [trt_pkg::CntW-1:0] One  = trt_pkg::CntW'(1);
  localparam logic [trt_pkg::CntW-1:0] FirstAddr = trt_pkg::CntW'(2);

  trt_pkg::state_t state_r, state_nxt;
  logic [2:0]               func_r, func_nxt;
  logic [trt_pkg::AddrW-1:0] tgt_r, tgt_nxt, par_r, par_nxt;
  logic [trt_pkg::CntW-1:0]  idx_r, idx_nxt;   // scan index
  logic [trt_pkg::CntW-1:0]  stp_r, stp_nxt;   // walk step count
  logic [trt_pkg::AddrW-1:0] x_r, x_nxt;       // walk position
  logic [trt_pkg::AddrW-1:0] res_r, res_nxt;
  logic                      ok_r, ok_nxt;
  logic [trt_pkg::AddrW-1:0] walk_x;
  logic                      walk_hit, walk_stop;

  // chain walk compare; the first step tests the stored parent itself
  assign walk_x    = (stp_r != '0) ? rdata : x_r;
  assign walk_hit  = (stp_r != Lim) && (walk_x == tgt_r || walk_x == '0);
  assign walk_stop = (stp_r == Lim) || walk_hit || (walk_x == self_addr);

  // next state and data path
  always_comb begin
    state_nxt = state_r;
    func_nxt = func_r; tgt_nxt = tgt_r; par_nxt = par_r;
    idx_nxt = idx_r; stp_nxt = stp_r; x_nxt = x_r;
    res_nxt = res_r; ok_nxt = ok_r;
    unique case (state_r)
      trt_pkg::ST_INIT: begin
        idx_nxt = idx_r + One;
        if (idx_r == Last) state_nxt = trt_pkg::ST_IDLE;
      end
      trt_pkg::ST_IDLE: begin
        if (start) begin
          func_nxt = func; tgt_nxt = tgt;
          par_nxt  = (par == '0) ? self_addr : par;
          res_nxt  = '0; ok_nxt = 1'b0;
          idx_nxt  = FirstAddr;
          unique case (func)
            trt_pkg::FUNC_ALLOC:  state_nxt = trt_pkg::ST_ALLOC_RD;
            trt_pkg::FUNC_ADD: begin
              ok_nxt = 1'b1; state_nxt = trt_pkg::ST_DONE;
            end
            trt_pkg::FUNC_DELETE: state_nxt = trt_pkg::ST_DEL_RD;
            trt_pkg::FUNC_ROUTE: begin
              x_nxt = tgt; stp_nxt = '0; state_nxt = trt_pkg::ST_ROUTE_RD;
            end
            trt_pkg::FUNC_REINIT: begin
              idx_nxt = '0; state_nxt = trt_pkg::ST_CLEAR;
            end
            default: state_nxt = trt_pkg::ST_DONE;
          endcase
        end
      end
      trt_pkg::ST_CLEAR: begin
        idx_nxt = idx_r + One;
        if (idx_r == Lim) begin
          ok_nxt = 1'b1; state_nxt = trt_pkg::ST_DONE;
        end
      end
      trt_pkg::ST_ALLOC_RD: begin
        if (idx_r == Lim) state_nxt = trt_pkg::ST_DONE;
        else state_nxt = trt_pkg::ST_ALLOC_CHK;
      end
      trt_pkg::ST_ALLOC_CHK: begin
        if (rdata == '0) begin
          res_nxt = idx_r[trt_pkg::AddrW-1:0]; ok_nxt = 1'b1;
          state_nxt = trt_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r + One; state_nxt = trt_pkg::ST_ALLOC_RD;
        end
      end
      trt_pkg::ST_DEL_RD: begin
        if (idx_r == Lim) begin
          ok_nxt = 1'b1; state_nxt = trt_pkg::ST_DONE;
        end else state_nxt = trt_pkg::ST_DEL_CHK;
      end
      trt_pkg::ST_DEL_CHK: begin
        x_nxt = rdata; stp_nxt = '0; state_nxt = trt_pkg::ST_WALK_CHK;
      end
      trt_pkg::ST_WALK_RD: state_nxt = trt_pkg::ST_WALK_CHK;
      trt_pkg::ST_WALK_CHK: begin
        // one chain step per visit; stop on hit, local node or step bound
        if (walk_stop) begin
          idx_nxt = idx_r + One; state_nxt = trt_pkg::ST_DEL_RD;
        end else begin
          x_nxt = walk_x; stp_nxt = stp_r + One; state_nxt = trt_pkg::ST_WALK_RD;
        end
      end
      trt_pkg::ST_ROUTE_RD: begin
        if (stp_r == Lim) state_nxt = trt_pkg::ST_DONE;
        else state_nxt = trt_pkg::ST_ROUTE_CHK;
      end
      trt_pkg::ST_ROUTE_CHK: begin
        if (rdata == self_addr) begin
          res_nxt = x_r; ok_nxt = 1'b1; state_nxt = trt_pkg::ST_DONE;
        end else begin
          x_nxt = rdata; stp_nxt = stp_r + One; state_nxt = trt_pkg::ST_ROUTE_RD;
        end
      end
      trt_pkg::ST_DONE: if (res_taken) state_nxt = trt_pkg::ST_IDLE;
      default: state_nxt = trt_pkg::ST_IDLE;
    endcase
  end

  // table port and outputs
  always_comb begin
    req = '0;
    req.raddr = idx_r[trt_pkg::AddrW-1:0];
    unique case (state_r)
      trt_pkg::ST_INIT: begin
        req.we = 1'b1;
        req.waddr = idx_r[trt_pkg::AddrW-1:0];
        req.wdata = '0;
      end
      trt_pkg::ST_IDLE: begin
        // add writes its entry; delete clears the target before the scan
        req.we = start && (func == trt_pkg::FUNC_ADD || func == trt_pkg::FUNC_DELETE);
        req.waddr = tgt;
        req.wdata = (func == trt_pkg::FUNC_ADD) ? par : '0;
      end
      trt_pkg::ST_CLEAR: begin
        req.we = 1'b1;
        req.waddr = (idx_r == Lim) ? self_addr : idx_r[trt_pkg::AddrW-1:0];
        req.wdata = (idx_r == Lim) ? self_addr : '0;
      end
      trt_pkg::ST_ALLOC_CHK: begin
        req.we = (rdata == '0) && (par_r != '0);
        req.waddr = idx_r[trt_pkg::AddrW-1:0]; req.wdata = par_r;
      end
      trt_pkg::ST_WALK_RD: req.raddr = x_r;
      trt_pkg::ST_WALK_CHK: begin
        // a hit clears the scanned entry at idx_r
        req.we = walk_hit;
        req.waddr = idx_r[trt_pkg::AddrW-1:0];
        req.wdata = '0;
        req.raddr = walk_x;
      end
      trt_pkg::ST_ROUTE_RD: req.raddr = x_r;
      trt_pkg::ST_DEL_RD: req.raddr = idx_r[trt_pkg::AddrW-1:0];
      default: ;
    endcase
  end

  assign busy = (state_r != trt_pkg::ST_IDLE);
  assign done = (state_r == trt_pkg::ST_DONE);
  assign res  = res_r;
  assign ok   = ok_r;

  // registers; reset starts the table clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trt_pkg::ST_INIT;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
    func_r <= func_nxt; tgt_r <= tgt_nxt; par_r <= par_nxt;
    stp_r <= stp_nxt; x_r <= x_nxt;
    res_r <= res_nxt; ok_r <= ok_nxt;
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done && res_taken |=> state_r == trt_pkg::ST_IDLE) else $error("done not released");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    done && !res_taken |=> done && $stable(res_r) && $stable(ok_r))
    else $error("result changed while waiting");
  a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    done && ok && func_r == trt_pkg::FUNC_ALLOC |-> res_r >= 8'd2) else $error("bad alloc");
`endif

endmodule : trt_seq

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tree route table. Drives allocate, add, delete,
// route, reinit and unknown-code items on the input stream, predicts each
// result from a local copy of the parent table or a directed row and compares
// it field by field on the output stream. Runs several local addresses and
// several sender and receiver idling phases, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned HalfPeriod = 6;
  localparam int unsigned CycleLimit = 20000000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainWait  = 1200;
  localparam int unsigned PhaseItems = 44;
  localparam logic [2:0]  FuncBad5   = 3'd5;
  localparam logic [2:0]  FuncBad6   = 3'd6;
  localparam logic [2:0]  FuncBad7   = 3'd7;

  typedef struct {
    logic [2:0] func;
    logic [7:0] tgt;
    logic [7:0] par;
    bit         typed;
    logic [7:0] res;
    logic       ok;
  } row_t;

  typedef struct {
    logic [7:0] res;
    logic       ok;
  } route_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  // predictor state
  logic [7:0]  parent_of [trt_pkg::TableEntries];
  logic [7:0]  node_addr = '0;
  route_res_t  pending_q[$];
  int          n_errors = 0;
  int          cycle_cnt = 0;

  // idling controls, read by the stream processes
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          rx_hold = 1'b0;
  int          hold_cnt = 0;

  always #(HalfPeriod) clk = ~clk;

  tree_route_table_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // chain from x meets the deleted address or 0 before the local node
  function automatic bit chain_meets(logic [7:0] x, logic [7:0] gone);
    for (int n = 0; n < trt_pkg::TableEntries; n++) begin
      if (x == gone || x == '0) return 1'b1;
      if (x == node_addr) return 1'b0;
      x = parent_of[x];
    end
    return 1'b0;
  endfunction

  // apply one item to the table copy and return its result
  function automatic route_res_t apply_item(logic [2:0] func, logic [7:0] tgt,
                                            logic [7:0] par);
    route_res_t r;
    logic [7:0] p;
    logic [7:0] x;
    r.res = '0;
    r.ok  = 1'b0;
    case (func)
      trt_pkg::FUNC_ALLOC: begin
        p = (par == '0) ? node_addr : par;
        for (int i = 2; i < trt_pkg::TableEntries; i++) begin
          if (parent_of[i] == '0) begin
            parent_of[i] = p;
            r.res = 8'(i);
            r.ok  = 1'b1;
            break;
          end
        end
      end
      trt_pkg::FUNC_ADD: begin
        parent_of[tgt] = par;
        r.ok = 1'b1;
      end
      trt_pkg::FUNC_DELETE: begin
        for (int i = 2; i < trt_pkg::TableEntries; i++) begin
          if (chain_meets(parent_of[i], tgt)) parent_of[i] = '0;
          parent_of[tgt] = '0;
        end
        r.ok = 1'b1;
      end
      trt_pkg::FUNC_ROUTE: begin
        x = tgt;
        for (int n = 0; n < trt_pkg::TableEntries; n++) begin
          p = parent_of[x];
          if (p == node_addr) begin
            r.res = x;
            r.ok  = 1'b1;
            break;
          end
          x = p;
        end
      end
      trt_pkg::FUNC_REINIT: begin
        foreach (parent_of[i]) parent_of[i] = '0;
        parent_of[node_addr] = node_addr;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("[%0t] mismatch %s: got 0x%02h want 0x%02h", $time, what, got, want);
    n_errors++;
  endtask

  // sender: holds tvalid high between items unless idling
  task automatic send_item(logic [2:0] func, logic [7:0] tgt, logic [7:0] par,
                           bit typed, logic [7:0] res, logic ok);
    route_res_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, par, tgt, func};
    do @(posedge clk); while (!in_tready);
    r = apply_item(func, tgt, par);
    if (typed) begin
      r.res = res;
      r.ok  = ok;
    end
    pending_q.push_back(r);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic set_node_addr(logic [7:0] a);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we    <= 1'b0;
    node_addr = a;
  endtask

  // mostly small, sparse trees so chain walks stay short
  task automatic random_item();
    int         pick;
    logic [7:0] tgt;
    logic [7:0] par;
    pick = $urandom_range(99);
    tgt  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2, 40));
    par  = ($urandom_range(2) == 0) ? node_addr
         : (($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40)));
    if (pick < 30)      send_item(trt_pkg::FUNC_ALLOC, 8'($urandom), par, 0, '0, 0);
    else if (pick < 50) send_item(trt_pkg::FUNC_ADD, tgt, par, 0, '0, 0);
    else if (pick < 54) send_item(trt_pkg::FUNC_DELETE, tgt, 8'($urandom), 0, '0, 0);
    else if (pick < 88) send_item(trt_pkg::FUNC_ROUTE, tgt, 8'($urandom), 0, '0, 0);
    else if (pick < 93) send_item(trt_pkg::FUNC_REINIT, 8'($urandom), 8'($urandom),
                                  0, '0, 0);
    else send_item(3'($urandom_range(FuncBad5, FuncBad7)), 8'($urandom),
                   8'($urandom), 0, '0, 0);
  endtask

  // receiver: random stalls, or one long hold-off
  always @(posedge clk) begin
    if (rx_hold && hold_cnt < HoldCycles) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    route_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[7:0], '0);
      end else begin
        want = pending_q.pop_front();
        if (out_tdata[7:0] !== want.res)
          report_mismatch("result_address", out_tdata[7:0], want.res);
        if (out_tdata[8] !== want.ok)
          report_mismatch("ok", {7'b0, out_tdata[8]}, {7'b0, want.ok});
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t       rows[$];
    logic [7:0] locals[5];
    foreach (parent_of[i]) parent_of[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, local node 1
    set_node_addr(8'd1);
    rows = '{
      '{trt_pkg::FUNC_REINIT, 8'd0,   8'd0,   1, 8'd0,   1'b1},
      '{trt_pkg::FUNC_ROUTE,  8'd1,   8'd0,   1, 8'd1,   1'b1},
      '{trt_pkg::FUNC_ALLOC,  8'd0,   8'd0,   1, 8'd2,   1'b1},
      '{trt_pkg::FUNC_ALLOC,  8'd0,   8'd2,   1, 8'd3,   1'b1},
      '{trt_pkg::FUNC_ADD,    8'd255, 8'd3,   1, 8'd0,   1'b1},
      '{trt_pkg::FUNC_ROUTE,  8'd255, 8'd0,   1, 8'd2,   1'b1},
      '{trt_pkg::FUNC_ROUTE,  8'd200, 8'd0,   1, 8'd0,   1'b0},
      '{FuncBad5,             8'd255, 8'd255, 1, 8'd0,   1'b0},
      '{FuncBad6,             8'd0,   8'd0,   1, 8'd0,   1'b0},
      '{FuncBad7,             8'd170, 8'd85,  1, 8'd0,   1'b0},
      '{trt_pkg::FUNC_DELETE, 8'd2,   8'd0,   1, 8'd0,   1'b1},
      '{trt_pkg::FUNC_ROUTE,  8'd255, 8'd0,   0, 8'd0,   1'b0},
      '{trt_pkg::FUNC_ADD,    8'd0,   8'd255, 0, 8'd0,   1'b0},
      '{trt_pkg::FUNC_ROUTE,  8'd0,   8'd0,   0, 8'd0,   1'b0},
      '{trt_pkg::FUNC_ADD,    8'd5,   8'd6,   0, 8'd0,   1'b0},
      '{trt_pkg::FUNC_ADD,    8'd6,   8'd5,   0, 8'd0,   1'b0},
      '{trt_pkg::FUNC_ROUTE,  8'd5,   8'd0,   0, 8'd0,   1'b0},
      '{trt_pkg::FUNC_DELETE, 8'd200, 8'd0,   0, 8'd0,   1'b0},
      '{trt_pkg::FUNC_ALLOC,  8'd255, 8'd255, 0, 8'd0,   1'b0},
      '{trt_pkg::FUNC_DELETE, 8'd1,   8'd0,   0, 8'd0,   1'b0}
    };
    foreach (rows[i])
      send_item(rows[i].func, rows[i].tgt, rows[i].par, rows[i].typed,
                rows[i].res, rows[i].ok);

    // fill the table to the last free entry and past it, local node 0;
    // the first allocate has no effective parent and leaves its entry free
    set_node_addr(8'd0);
    send_item(trt_pkg::FUNC_REINIT, '0, '0, 0, '0, 0);
    tx_idle_pct = 7;
    for (int i = 0; i < 256; i++)
      send_item(trt_pkg::FUNC_ALLOC, 8'($urandom),
                (i == 0) ? 8'd0 : 8'($urandom_range(1, 255)), 0, '0, 0);
    send_item(trt_pkg::FUNC_ROUTE, 8'd255, '0, 0, '0, 0);

    // random phases across local addresses and idling patterns
    locals = '{8'd255, 8'd0, 8'($urandom), 8'd2, 8'($urandom)};
    for (int ph = 0; ph < 5; ph++) begin
      set_node_addr(locals[ph]);
      tx_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 7 : 49) : 0;
      rx_stall_pct = (ph == 2) ? 49 : ((ph == 3) ? 7 : 0);
      rx_hold      = (ph == 4);
      send_item(trt_pkg::FUNC_REINIT, 8'($urandom), 8'($urandom), 0, '0, 0);
      for (int k = 0; k < PhaseItems; k++) random_item();
    end

    // drain
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/trt_pkg.sv
src/trt_ram.sv
src/trt_seq.sv
src/tree_route_table_top.sv
tb/sv/tb.sv
